@@ sv/cmbe_pkg.sv @@
// cmbe_pkg: shared types and constants for the combination enumerator
// used by cmbe_cell and combination_enumerator; no dependencies

package cmbe_pkg;

  // fixed field widths
  localparam int ELEM_W     = 32;
  localparam int FUNC_W     = 2;
  localparam int LOAD_IDX_W = 6;
  localparam int K_W        = 4;
  localparam int N_W        = 7;
  localparam int POS_W      = 3;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;

  // item function codes
  typedef enum logic [FUNC_W-1:0] {
    FUNC_LOAD    = 2'd0,
    FUNC_NEXT    = 2'd1,
    FUNC_RESTART = 2'd2
  } func_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_N_ITEMS  = 1'd0,
    REG_K_SELECT = 1'd1
  } cfg_reg_t;

  // control broadcast from the sequencer to every cell of the chain
  typedef struct packed {
    logic restart;
    logic start;
    logic shift;
  } cell_ctrl_t;

endpackage

@@ sv/combination_enumerator.sv @@
// combination_enumerator: top level, sequencer, config registers and cell chain
// depends on cmbe_pkg, cmbe_cell and cmbe_store
//
//   channel   signals                                   handshake
//   item      func, load_index, load_value              item_valid / item_stall
//   result    element, position, last_in_combination,   result_valid / result_stall
//             last_combination, exhausted
//   config    cfg_index, cfg_data                       cfg_write, no wait
//
// a load or restart item completes on acceptance; a next item is accepted and
// then gives k results, one per cycle while result_stall is low, each read from
// the store at the address shifted out of the cell chain; an exhausted next gives one.
// the refill wave moves one cell per cycle and finishes inside the emission.
// synchronous reset: indices zero, finished set, config zero, no result.
// result_stall freezes the output register and the tap shift, the refill wave
// runs on; the next item is taken while the last result of a combination
// still waits.

module combination_enumerator #(
  parameter int MAX_ELEMENTS = 64,
  parameter int MAX_K        = 8,
  parameter int VALUE_WIDTH  = 32
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_write,
  input  logic [cmbe_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [cmbe_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic                                  item_valid,
  output logic                                  item_stall,
  input  logic [cmbe_pkg::FUNC_W-1:0]           func,
  input  logic [cmbe_pkg::LOAD_IDX_W-1:0]       load_index,
  input  logic signed [cmbe_pkg::ELEM_W-1:0]    load_value,
  output logic                                  result_valid,
  input  logic                                  result_stall,
  output logic signed [cmbe_pkg::ELEM_W-1:0]    element,
  output logic [cmbe_pkg::POS_W-1:0]            position,
  output logic                                  last_in_combination,
  output logic                                  last_combination,
  output logic                                  exhausted
);

  localparam int IDX_W = $clog2(MAX_ELEMENTS > MAX_K ? MAX_ELEMENTS : MAX_K);
  localparam int NW    = $clog2(MAX_ELEMENTS + 1);
  localparam int CW    = IDX_W + 5;
  localparam int AW    = $clog2(MAX_ELEMENTS);

  typedef enum logic {ST_IDLE, ST_EMIT} state_t;

  state_t                       state;
  logic [cmbe_pkg::N_W-1:0]     n_items;
  logic [cmbe_pkg::K_W-1:0]     k_select;
  logic [cmbe_pkg::K_W-1:0]     cnt;
  logic                         exh_mode;
  logic                         last_comb_r;
  logic                         finished;
  logic                         zero_r;

  cmbe_pkg::func_t              fn;
  cmbe_pkg::cell_ctrl_t         cell_ctrl;
  logic                         accept;
  logic                         next_ok;
  logic                         out_en;
  logic                         issue;
  logic                         load_we;
  logic                         oob;
  logic                         more;
  logic [NW-1:0]                n_eff;
  logic [VALUE_WIDTH-1:0]       wdata;
  logic [VALUE_WIDTH-1:0]       rdata;

  logic [IDX_W-1:0]             idx_vec      [MAX_K];
  logic [IDX_W-1:0]             tap_vec      [MAX_K];
  logic [IDX_W-1:0]             idx_left_vec [MAX_K];
  logic [IDX_W-1:0]             tap_in_vec   [MAX_K];
  logic [MAX_K-1:0]             below_vec;
  logic [MAX_K-1:0]             carry_vec;
  logic [MAX_K-1:0]             carry_in_vec;
  logic [MAX_K-1:0]             pivot_vec;
  logic [MAX_K-1:0]             below_rev;
  logic [MAX_K-1:0]             iso_rev;

  // handshake and decode
  assign fn         = cmbe_pkg::func_t'(func);
  assign item_stall = (state != ST_IDLE);
  assign accept     = item_valid && !item_stall;
  assign out_en     = !result_valid || !result_stall;
  assign issue      = (state == ST_EMIT) && out_en;

  // element count clamped to the store size
  assign n_eff = (32'(n_items) > MAX_ELEMENTS) ? NW'(MAX_ELEMENTS) : NW'(n_items);

  // a combination is available
  assign next_ok = !finished && (k_select != '0) && (32'(k_select) <= MAX_K) &&
                   (n_eff != '0) && (32'(n_eff) >= 32'(k_select));

  // cell control
  assign cell_ctrl.restart = accept && (fn == cmbe_pkg::FUNC_RESTART);
  assign cell_ctrl.start   = accept && (fn == cmbe_pkg::FUNC_NEXT) && next_ok;
  assign cell_ctrl.shift   = issue && !exh_mode;

  // rightmost index below its ceiling: isolate the highest set flag
  assign more = |below_vec;
  always_comb begin
    for (int i = 0; i < MAX_K; i++) begin
      below_rev[i] = below_vec[MAX_K-1-i];
    end
    iso_rev = below_rev & (~below_rev + MAX_K'(1));
    for (int i = 0; i < MAX_K; i++) begin
      pivot_vec[i] = iso_rev[MAX_K-1-i];
    end
  end

  // cell chain
  for (genvar g = 0; g < MAX_K; g++) begin : g_cell
    if (g == 0) begin : g_first
      assign idx_left_vec[g] = '0;
      assign carry_in_vec[g] = 1'b0;
    end else begin : g_inner
      assign idx_left_vec[g] = idx_vec[g-1];
      assign carry_in_vec[g] = carry_vec[g-1];
    end
    if (g == MAX_K - 1) begin : g_last
      assign tap_in_vec[g] = '0;
    end else begin : g_mid
      assign tap_in_vec[g] = tap_vec[g+1];
    end

    cmbe_cell #(
      .POS   (g),
      .IDX_W (IDX_W),
      .NW    (NW),
      .CW    (CW)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (cell_ctrl),
      .n_eff    (n_eff),
      .k_sel    (k_select),
      .pivot    (pivot_vec[g]),
      .carry_in (carry_in_vec[g]),
      .idx_left (idx_left_vec[g]),
      .tap_in   (tap_in_vec[g]),
      .below    (below_vec[g]),
      .carry    (carry_vec[g]),
      .idx      (idx_vec[g]),
      .tap      (tap_vec[g])
    );
  end

  // element store
  assign load_we = accept && (fn == cmbe_pkg::FUNC_LOAD) && (32'(load_index) < MAX_ELEMENTS);
  assign wdata   = VALUE_WIDTH'(unsigned'(load_value));
  assign oob     = 32'(tap_vec[0]) >= MAX_ELEMENTS;

  cmbe_store #(
    .DEPTH (MAX_ELEMENTS),
    .AW    (AW),
    .DW    (VALUE_WIDTH)
  ) u_store (
    .clk   (clk),
    .we    (load_we),
    .waddr (AW'(load_index)),
    .wdata (wdata),
    .re    (issue),
    .raddr (tap_vec[0][AW-1:0]),
    .rdata (rdata)
  );

  // element comes from the store read register, forced to zero for an exhausted or out-of-range result
  assign element = zero_r ? '0 : signed'(cmbe_pkg::ELEM_W'(rdata));

  // sequencer, config registers and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      result_valid <= 1'b0;
      finished     <= 1'b1;
      n_items      <= '0;
      k_select     <= '0;
      cnt          <= '0;
      exh_mode     <= 1'b0;
      last_comb_r  <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (cmbe_pkg::cfg_reg_t'(cfg_index))
          cmbe_pkg::REG_N_ITEMS:  n_items  <= cfg_data;
          cmbe_pkg::REG_K_SELECT: k_select <= cfg_data[cmbe_pkg::K_W-1:0];
          default: ;
        endcase
      end
      if (cell_ctrl.restart) begin
        finished <= 1'b0;
      end
      // output register loads a new result or empties once taken
      if (out_en) begin
        result_valid <= (state == ST_EMIT);
      end
      unique case (state)
        ST_IDLE: begin
          if (accept && (fn == cmbe_pkg::FUNC_NEXT)) begin
            state       <= ST_EMIT;
            cnt         <= '0;
            exh_mode    <= !next_ok;
            last_comb_r <= !more;
            if (next_ok && !more) begin
              finished <= 1'b1;
            end
          end
        end
        ST_EMIT: begin
          if (out_en) begin
            position            <= cnt[cmbe_pkg::POS_W-1:0];
            exhausted           <= exh_mode;
            last_in_combination <= !exh_mode && ((cnt + cmbe_pkg::K_W'(1)) == k_select);
            last_combination    <= !exh_mode && last_comb_r;
            zero_r              <= exh_mode || oob;
            cnt                 <= cnt + cmbe_pkg::K_W'(1);
            if (exh_mode || ((cnt + cmbe_pkg::K_W'(1)) == k_select)) begin
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // refill wave never outlives the emission of its combination
  a_carry_busy: assert property (@(posedge clk) disable iff (rst)
    (carry_vec != '0) |-> (state == ST_EMIT))
    else $error("refill wave active while sequencer idle");

  // at most one pivot cell
  a_pivot_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0(pivot_vec))
    else $error("more than one pivot cell");

  // emission count stays below k
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) && !exh_mode |-> (cnt < k_select))
    else $error("emission count beyond k");

  // exhausted result carries no element
  a_exh_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && exhausted |-> (element == '0) && !last_in_combination && !last_combination)
    else $error("exhausted result with payload");

  // last combination leaves the enumeration finished
  a_finish: assert property (@(posedge clk) disable iff (rst)
    issue && !exh_mode && last_comb_r |-> finished)
    else $error("last combination emitted without finished set");

endmodule

@@ sv/cmbe_cell.sv @@
// cmbe_cell: one index cell of the chain, holds one chosen index and a tap copy
// depends on cmbe_pkg

module cmbe_cell #(
  parameter int POS   = 0,
  parameter int IDX_W = 6,
  parameter int NW    = 7,
  parameter int CW    = 11
) (
  input  logic                       clk,
  input  logic                       rst,
  input  cmbe_pkg::cell_ctrl_t       ctrl,
  input  logic [NW-1:0]              n_eff,
  input  logic [cmbe_pkg::K_W-1:0]   k_sel,
  input  logic                       pivot,
  input  logic                       carry_in,
  input  logic [IDX_W-1:0]           idx_left,
  input  logic [IDX_W-1:0]           tap_in,
  output logic                       below,
  output logic                       carry,
  output logic [IDX_W-1:0]           idx,
  output logic [IDX_W-1:0]           tap
);

  logic active;

  // cell takes part in the combination when its position is below k
  assign active = 32'(k_sel) > POS;

  // index still below its ceiling n - k + pos, written without subtraction
  assign below = active && ((CW'(idx) + CW'(k_sel)) < (CW'(n_eff) + CW'(POS)));

  // index update: restart, refill wave from the left, or pivot increment
  always_ff @(posedge clk) begin
    if (rst) begin
      idx   <= '0;
      carry <= 1'b0;
    end else if (ctrl.restart) begin
      idx   <= IDX_W'(POS);
      carry <= 1'b0;
    end else if (carry_in && active) begin
      idx   <= idx_left + IDX_W'(1);
      carry <= 1'b1;
    end else if (ctrl.start && pivot) begin
      idx   <= idx + IDX_W'(1);
      carry <= 1'b1;
    end else begin
      carry <= 1'b0;
    end
  end

  // tap copy loads the index on start and shifts toward cell 0 to address the store
  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      tap <= idx;
    end else if (ctrl.shift) begin
      tap <= tap_in;
    end
  end

endmodule

@@ sv/cmbe_store.sv @@
// cmbe_store: element store, one write port and one registered read port
// depends on cmbe_pkg only through the instantiating module

module cmbe_store #(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int DW    = 32
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, data held while not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
